@@ hw/rtl/ssjq_pkg.sv @@
`default_nettype none

package ssjq_pkg;

    // Field widths
    localparam int ID_W   = 16;
    localparam int SIZE_W = 24;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 5;

    // Default number of queue entries
    localparam int DEPTH_DEF = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_KILL = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_NONE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    // One queue entry
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
    } t_entry;

    // One finished result
    typedef struct packed {
        logic [ST_W-1:0]  status;
        t_entry           job;
        logic [OCC_W-1:0] occ;
    } t_result;

    // Memory write request
    typedef struct packed {
        logic   we;
        t_entry data;
    } t_wr_req;

    // Compare unit modes
    typedef enum logic [1:0] {
        CMP_LT,
        CMP_LE,
        CMP_EQ
    } t_cmp_mode;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_ENQ_LAST,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

@@ hw/rtl/ssjq_mem.sv @@
`default_nettype none

module ssjq_mem
    import ssjq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int IW = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire t_wr_req       i_wr,
    input  wire logic [IW-1:0] i_waddr,
    input  wire logic [IW-1:0] i_raddr,
    output t_entry             o_rdata
);

    t_entry r_mem [DEPTH];

    // Write one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_waddr] <= i_wr.data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/ssjq_cmp.sv @@
`default_nettype none

module ssjq_cmp
    import ssjq_pkg::*;
(
    input  wire t_cmp_mode         i_mode,
    input  wire t_entry            i_entry,
    input  wire logic [SIZE_W-1:0] i_key_size,
    input  wire logic [ID_W-1:0]   i_key_id,
    output logic                   o_hit
);

    // Shared compare: insertion point, fit test or id match
    always_comb begin
        unique case (i_mode)
            CMP_LT:  o_hit = i_entry.size < i_key_size;
            CMP_LE:  o_hit = i_entry.size <= i_key_size;
            CMP_EQ:  o_hit = i_entry.id == i_key_id;
            default: o_hit = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/ssjq_seq.sv @@
`default_nettype none

module ssjq_seq
    import ssjq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int IW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [ID_W-1:0]   i_job_id,
    input  wire logic [SIZE_W-1:0] i_job_size,
    input  wire logic [SIZE_W-1:0] i_size_limit,
    output t_wr_req                o_wr,
    output logic [IW-1:0]          o_waddr,
    output logic [IW-1:0]          o_raddr,
    input  wire t_entry            i_rdata,
    output t_cmp_mode              o_cmp_mode,
    output logic [SIZE_W-1:0]      o_cmp_key_size,
    output logic [ID_W-1:0]        o_cmp_key_id,
    input  wire logic              i_cmp_hit,
    output logic                   o_res_valid,
    output t_result                o_res,
    input  wire logic              i_res_ready
);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_ptr, n_ptr;
    logic              r_found, n_found;
    logic [OP_W-1:0]   r_op, n_op;
    logic [SIZE_W-1:0] r_key_size, n_key_size;
    logic [ID_W-1:0]   r_key_id, n_key_id;
    t_entry            r_hit, n_hit;
    logic [ST_W-1:0]   r_status, n_status;

    logic          w_acc;
    logic          w_full;
    logic          w_empty;
    logic          w_last;
    logic [CW-1:0] w_cnt_m1;
    logic [31:0]   w_cnt_ext;
    t_entry        w_key;

    assign w_acc     = i_in_valid && o_in_ready;
    assign w_full    = r_count == CW'(DEPTH);
    assign w_empty   = r_count == '0;
    assign w_cnt_m1  = r_count - CW'(1);
    assign w_last    = CW'(r_ptr) == w_cnt_m1;
    assign w_cnt_ext = 32'(r_count);
    assign w_key     = '{id: r_key_id, size: r_key_size};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_op) inside
                        OP_ENQ: begin
                            if (w_full || w_empty) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_ENQ;
                            end
                        end
                        OP_DEQ, OP_KILL: begin
                            n_state = w_empty ? S_DONE : S_SCAN;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_ENQ: begin
                if (!i_cmp_hit) begin
                    n_state = S_DONE;
                end else if (r_ptr == '0) begin
                    n_state = S_ENQ_LAST;
                end
            end
            S_ENQ_LAST: n_state = S_DONE;
            S_SCAN: begin
                if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath register updates
    always_comb begin
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_found    = r_found;
        n_op       = r_op;
        n_key_size = r_key_size;
        n_key_id   = r_key_id;
        n_hit      = r_hit;
        n_status   = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_op       = i_op;
                    n_key_id   = i_job_id;
                    n_key_size = (i_op == OP_ENQ) ? i_job_size : i_size_limit;
                    n_found    = 1'b0;
                    n_hit      = '0;
                    n_status   = ST_NONE;
                    n_ptr      = '0;
                    if (i_op == OP_ENQ) begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else if (w_empty) begin
                            n_count  = r_count + CW'(1);
                            n_status = ST_OK;
                        end else begin
                            n_ptr = w_cnt_m1[IW-1:0];
                        end
                    end
                end
            end
            S_ENQ: begin
                if (i_cmp_hit) begin
                    n_ptr = r_ptr - IW'(1);
                end else begin
                    n_count  = r_count + CW'(1);
                    n_status = ST_OK;
                end
            end
            S_ENQ_LAST: begin
                n_count  = r_count + CW'(1);
                n_status = ST_OK;
            end
            S_SCAN: begin
                if (!r_found && i_cmp_hit) begin
                    n_found = 1'b1;
                    n_hit   = i_rdata;
                end
                n_ptr = r_ptr + IW'(1);
                if (w_last && (r_found || i_cmp_hit)) begin
                    n_count  = r_count - CW'(1);
                    n_status = ST_OK;
                end
            end
            default: ;
        endcase
    end

    // Memory, compare and result controls
    always_comb begin
        o_in_ready     = r_state == S_IDLE;
        o_wr           = '0;
        o_waddr        = '0;
        o_raddr        = '0;
        o_cmp_mode     = CMP_LT;
        o_cmp_key_size = r_key_size;
        o_cmp_key_id   = r_key_id;
        o_res_valid    = r_state == S_DONE;
        o_res          = '{status: r_status, job: r_hit, occ: w_cnt_ext[OCC_W-1:0]};
        unique case (r_state)
            S_IDLE: begin
                // prefetch the tail for insertion, the head for a scan
                o_raddr = (i_op == OP_ENQ) ? w_cnt_m1[IW-1:0] : '0;
                if (w_acc && i_op == OP_ENQ && !w_full && w_empty) begin
                    o_wr.we   = 1'b1;
                    o_wr.data = '{id: i_job_id, size: i_job_size};
                end
            end
            S_ENQ: begin
                o_raddr  = r_ptr - IW'(1);
                o_waddr  = r_ptr + IW'(1);
                o_wr.we  = 1'b1;
                // move a smaller entry back, else drop the new job in behind it
                o_wr.data = i_cmp_hit ? i_rdata : w_key;
            end
            S_ENQ_LAST: begin
                o_wr.we   = 1'b1;
                o_wr.data = w_key;
            end
            S_SCAN: begin
                o_raddr    = r_ptr + IW'(1);
                o_cmp_mode = (r_op == OP_DEQ) ? CMP_LE : CMP_EQ;
                // close the gap behind the removed entry
                if (r_found) begin
                    o_wr.we   = 1'b1;
                    o_wr.data = i_rdata;
                    o_waddr   = r_ptr - IW'(1);
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // State and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_found <= n_found;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_op       <= n_op;
        r_key_size <= n_key_size;
        r_key_id   <= n_key_id;
        r_hit      <= n_hit;
        r_status   <= n_status;
    end

endmodule

`default_nettype wire

@@ hw/rtl/size_sorted_job_queue_top.sv @@
// Job queue sorted by size, largest first; equal sizes keep arrival order.
// Input channel (i_in_valid / o_in_ready) carries one operation item:
// enqueue (id, size), dequeue the largest job not above i_size_limit, or
// kill the first job with a given id. Each item yields exactly one result
// item on the output channel (o_out_valid / i_out_ready) with a status,
// the removed job (zero unless one was removed) and the occupancy after it.
// Timing: one item walks the held entries through a memory with separate
// read and write ports and one shared compare unit, one entry per cycle.
// Full, empty and unknown operations finish without a walk. The input is
// not ready while an item is being worked on.
// The result sits in an output register; the next item is accepted while it
// waits, but that item does not finish until the register has been taken.
// A stalled receiver holds the result steady and blocks further completions.
// Reset (synchronous, active low) empties the queue; no clearing pass is
// needed and the block is ready in the first cycle after reset.
`default_nettype none

module size_sorted_job_queue_top
    import ssjq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [ID_W-1:0]   i_job_id,
    input  wire logic [SIZE_W-1:0] i_job_size,
    input  wire logic [SIZE_W-1:0] i_size_limit,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [ST_W-1:0]        o_status,
    output logic [ID_W-1:0]        o_out_job_id,
    output logic [SIZE_W-1:0]      o_out_job_size,
    output logic [OCC_W-1:0]       o_occupancy
);

    localparam int IW = $clog2(DEPTH);

    t_wr_req       w_wr;
    logic [IW-1:0] w_waddr;
    logic [IW-1:0] w_raddr;
    t_entry        w_rdata;
    t_cmp_mode     w_cmp_mode;
    logic [SIZE_W-1:0] w_key_size;
    logic [ID_W-1:0]   w_key_id;
    logic          w_hit;
    logic          w_res_valid;
    t_result       w_res;
    logic          w_slot_free;

    logic    r_out_valid;
    t_result r_out;

    ssjq_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_waddr (w_waddr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ssjq_cmp u_cmp (
        .i_mode     (w_cmp_mode),
        .i_entry    (w_rdata),
        .i_key_size (w_key_size),
        .i_key_id   (w_key_id),
        .o_hit      (w_hit)
    );

    ssjq_seq #(.DEPTH(DEPTH)) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_job_id       (i_job_id),
        .i_job_size     (i_job_size),
        .i_size_limit   (i_size_limit),
        .o_wr           (w_wr),
        .o_waddr        (w_waddr),
        .o_raddr        (w_raddr),
        .i_rdata        (w_rdata),
        .o_cmp_mode     (w_cmp_mode),
        .o_cmp_key_size (w_key_size),
        .o_cmp_key_id   (w_key_id),
        .i_cmp_hit      (w_hit),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res),
        .i_res_ready    (w_slot_free)
    );

    // Output register: load a finished result when the slot is free
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_slot_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_out_job_id   = r_out.job.id;
    assign o_out_job_size = r_out.job.size;
    assign o_occupancy    = r_out.occ;

`ifndef SYNTHESIS
    localparam logic [31:0] DEPTH_U = 32'(DEPTH);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready while an item is in progress");

    a_full_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_occupancy == DEPTH_U[OCC_W-1:0]))
        else $error("full status with wrong occupancy");

    a_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
            (o_out_job_id == '0 && o_out_job_size == '0))
        else $error("job returned without ok status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_NONE || o_status == ST_FULL))
        else $error("unknown status code");
`endif

endmodule

`default_nettype wire

@@ tb/tb_size_sorted_job_queue_top.sv @@
`timescale 1ns / 100ps

module tb_size_sorted_job_queue_top;
    import ssjq_pkg::*;

    localparam int QDEPTH = DEPTH_DEF;
    localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;
    localparam int SETTLE_CYCLES = QDEPTH + 8;
    localparam int MIX_ITEMS = 600;
    localparam int BURST_ITEMS = 450;
    localparam int STREAM_ITEMS = 350;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [OP_W-1:0]   in_op;
    logic [ID_W-1:0]   in_job_id;
    logic [SIZE_W-1:0] in_job_size;
    logic [SIZE_W-1:0] in_size_limit;
    logic              out_valid;
    logic              out_ready;
    logic [ST_W-1:0]   out_status;
    logic [ID_W-1:0]   out_job_id;
    logic [SIZE_W-1:0] out_job_size;
    logic [OCC_W-1:0]  out_occupancy;

    // Predicted queue contents, largest size first
    logic [ID_W-1:0]   held_id   [QDEPTH];
    logic [SIZE_W-1:0] held_size [QDEPTH];
    int                held_count = 0;

    t_result pending_results [$];
    int      error_count = 0;
    int      sent_items = 0;
    int      gap_max = 15;
    int      stall_max = 15;

    size_sorted_job_queue_top uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_op           (in_op),
        .i_job_id       (in_job_id),
        .i_job_size     (in_job_size),
        .i_size_limit   (in_size_limit),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_status       (out_status),
        .o_out_job_id   (out_job_id),
        .o_out_job_size (out_job_size),
        .o_occupancy    (out_occupancy)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one operation to the predicted queue and return its result
    function automatic t_result queue_step(input logic [OP_W-1:0] op,
                                           input logic [ID_W-1:0] id,
                                           input logic [SIZE_W-1:0] size,
                                           input logic [SIZE_W-1:0] limit);
        t_result r;
        int      pos;
        bit      hit;
        r.status = ST_NONE;
        r.job    = '0;
        case (op)
            OP_ENQ: begin
                if (held_count >= QDEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // insert ahead of the first strictly smaller job
                    pos = held_count;
                    for (int i = 0; i < held_count; i++) begin
                        if (held_size[i] < size) begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = held_count; i > pos; i--) begin
                        held_size[i] = held_size[i-1];
                        held_id[i]   = held_id[i-1];
                    end
                    held_size[pos] = size;
                    held_id[pos]   = id;
                    held_count++;
                    r.status = ST_OK;
                end
            end
            OP_DEQ, OP_KILL: begin
                pos = -1;
                for (int i = 0; i < held_count; i++) begin
                    hit = (op == OP_DEQ) ? (held_size[i] <= limit) : (held_id[i] == id);
                    if (hit) begin
                        pos = i;
                        break;
                    end
                end
                // take the first match and close the gap
                if (pos >= 0) begin
                    r.status   = ST_OK;
                    r.job.id   = held_id[pos];
                    r.job.size = held_size[pos];
                    for (int i = pos; i < held_count - 1; i++) begin
                        held_size[i] = held_size[i+1];
                        held_id[i]   = held_id[i+1];
                    end
                    held_count--;
                end
            end
            default: begin
            end
        endcase
        r.occ = OCC_W'(held_count);
        return r;
    endfunction

    // Random field values, biased towards collisions with held jobs
    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(3, 0))
            0: return ID_W'($urandom_range(7, 0));
            1: return (held_count > 0) ? held_id[$urandom_range(held_count - 1, 0)]
                                       : ID_W'($urandom());
            default: return ID_W'($urandom());
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(4, 0))
            0: return SIZE_W'($urandom_range(7, 0));
            1: return {SIZE_W{1'b1}} - SIZE_W'($urandom_range(7, 0));
            2: return (held_count > 0) ? held_size[$urandom_range(held_count - 1, 0)]
                                       : SIZE_W'($urandom());
            default: return SIZE_W'($urandom());
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_limit();
        logic [SIZE_W-1:0] s;
        s = (held_count > 0) ? held_size[$urandom_range(held_count - 1, 0)] : '0;
        case ($urandom_range(3, 0))
            0: return s;
            1: return s - 1'b1;
            2: return pick_size();
            default: return SIZE_W'($urandom());
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int enq_pct);
        if ($urandom_range(99, 0) < enq_pct)
            return OP_ENQ;
        case ($urandom_range(9, 0))
            0: return OP_UNDEF;
            1, 2, 3, 4, 5: return OP_DEQ;
            default: return OP_KILL;
        endcase
    endfunction

    // Send one item after a random gap and record its expected result
    task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [SIZE_W-1:0] size, input logic [SIZE_W-1:0] limit);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        in_op         <= op;
        in_job_id     <= id;
        in_job_size   <= size;
        in_size_limit <= limit;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(queue_step(op, id, size, limit));
        sent_items++;
    endtask

    task automatic send_random(input int enq_pct);
        send_item(pick_op(enq_pct), pick_id(), pick_size(), pick_limit());
    endtask

    // Hold the sender idle until every outstanding result has been taken
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_empty_queue();
        send_item(OP_DEQ, '0, '0, '1);
        send_item(OP_KILL, '0, '0, '0);
        send_item(OP_UNDEF, '0, '0, '0);
    endtask

    task automatic test_fill_and_overflow();
        logic [SIZE_W-1:0] size;
        logic [ID_W-1:0]   id;
        // zero size, top size and groups of equal sizes
        for (int i = 0; i < QDEPTH; i++) begin
            size = (i == 0) ? '0 : (i == 1) ? '1 : SIZE_W'((i % 4) * 1000 + 1);
            id   = (i == 1) ? '1 : ID_W'(i);
            send_item(OP_ENQ, id, size, '0);
        end
        send_item(OP_ENQ, 16'hABCD, 24'd5, '1);
        send_item(OP_UNDEF, '1, '1, '1);
    endtask

    task automatic test_directed_removal();
        send_item(OP_DEQ, '1, '1, '0);
        send_item(OP_KILL, '1, '0, '0);
        send_item(OP_KILL, 16'h1234, '0, '1);
        send_item(OP_DEQ, '0, '0, '1);
        send_item(OP_DEQ, '0, '0, '0);
    endtask

    task automatic test_random_mix();
        gap_max   = 15;
        stall_max = 15;
        repeat (MIX_ITEMS / 2) send_random(50);
        wait_for_results();
        repeat (MIX_ITEMS / 2) send_random(50);
    endtask

    task automatic test_fill_drain_bursts();
        int stop_at;
        int round;
        stop_at = sent_items + BURST_ITEMS;
        round   = 0;
        while (sent_items < stop_at) begin
            // fill, possibly past the top, then drain mostly by dequeue and kill
            repeat ($urandom_range(QDEPTH + 4, 4)) send_random(90);
            if (round == 0 || $urandom_range(3, 0) == 0)
                wait_for_results();
            repeat ($urandom_range(QDEPTH + 4, 4)) send_random(5);
            round++;
        end
    endtask

    task automatic test_back_to_back();
        gap_max   = 0;
        stall_max = 0;
        repeat (STREAM_ITEMS / 2) send_random(50);
        stall_max = 15;
        repeat (STREAM_ITEMS / 2) send_random(50);
    endtask

    // Result sink with random stalls
    initial begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = $urandom_range(stall_max, 0);
            if (stall > 0) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d id %0h size %0h occupancy %0d",
                         $time, out_status, out_job_id, out_job_size, out_occupancy);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_status !== want.status) begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want.status, out_status);
                    error_count++;
                end
                if (out_job_id !== want.job.id) begin
                    $display("%0t: job id expected %0h, actual %0h",
                             $time, want.job.id, out_job_id);
                    error_count++;
                end
                if (out_job_size !== want.job.size) begin
                    $display("%0t: job size expected %0h, actual %0h",
                             $time, want.job.size, out_job_size);
                    error_count++;
                end
                if (out_occupancy !== want.occ) begin
                    $display("%0t: occupancy expected %0d, actual %0d",
                             $time, want.occ, out_occupancy);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("size_sorted_job_queue_top test failed");
        $finish;
    end

    initial begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_op         = OP_ENQ;
        in_job_id     = '0;
        in_job_size   = '0;
        in_size_limit = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_fill_and_overflow();
        test_directed_removal();
        test_random_mix();
        test_fill_drain_bursts();
        test_back_to_back();

        @(negedge clk);
        in_valid <= 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("size_sorted_job_queue_top test passed");
        end else begin
            $display("size_sorted_job_queue_top test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ssjq_pkg.sv
hw/rtl/ssjq_mem.sv
hw/rtl/ssjq_cmp.sv
hw/rtl/ssjq_seq.sv
hw/rtl/size_sorted_job_queue_top.sv
tb/tb_size_sorted_job_queue_top.sv
